[src/imu_fd_pkg.sv]
// Shared types and constants of the sensor frame decoder.
package imu_fd_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'h59;
    localparam logic [7:0] HDR_SECOND  = 8'h53;
    localparam logic [8:0] COUNT_MAX   = 9'h1ff;
    localparam int unsigned MIN_FRAME  = 7;
    localparam int unsigned NUM_KINDS  = 6;

    typedef enum logic [2:0] {
        KIND_ACCEL   = 3'd0,
        KIND_RATE    = 3'd1,
        KIND_MAG     = 3'd2,
        KIND_RAW_MAG = 3'd3,
        KIND_EULER   = 3'd4,
        KIND_QUAT    = 3'd5,
        KIND_STATUS  = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_HEADER   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_CHECKSUM = 3'd4
    } status_t;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_ACCEL   = 3'd0;
    localparam logic [2:0] REG_QUAT    = 3'd5;

    typedef struct packed {
        status_t    status;
        logic [7:0] plen;
    } job_t;

    // Data bytes of one record of the given kind
    function automatic logic [4:0] kind_len(input logic [2:0] k);
        kind_len = (k == KIND_QUAT) ? 5'd16 : 5'd12;
    endfunction

endpackage

[src/imu_frame_decoder_core.sv]
// Top level of the sensor frame decoder: configuration registers, front, queue and back.
//
//  channel   direction  handshake            payload
//  in        to block   in_valid/in_stall    rx_byte, frame_end
//  out       from block out_valid/out_stall  record_kind, value_0..3, frame_status, last_item
//  config    to block   APB psel/penable     paddr, pwdata, prdata
//
// Take one byte a cycle while no frame waits in the queue or is being walked; the front
// updates header flag, sums and payload memory with each word. At the frame's last word
// the front queues a job, and in_stall stays high until the back has drained it. The back's
// walk is bounded by its single memory read port; an emitted word waits out out_stall.
// Reset clears all control state; the payload memory is never cleared.
module imu_frame_decoder_core
    import imu_fd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               frame_end,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         record_kind,
    output logic signed [31:0] value_0,
    output logic signed [31:0] value_1,
    output logic signed [31:0] value_2,
    output logic signed [31:0] value_3,
    output logic [2:0]         frame_status,
    output logic               last_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    logic [7:0]    cfg_id_reg [NUM_KINDS];
    logic [2:0]    reg_idx;
    logic          accept;
    logic          push;
    job_t          push_job;
    logic          pop;
    job_t          head;
    logic          q_empty;
    logic          q_full;
    logic          busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [31:0]   v0, v1, v2, v3;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    // Register reads; addresses beyond the list read zero
    always_comb
    begin
        if (reg_idx <= REG_QUAT)
            prdata = {24'd0, cfg_id_reg[reg_idx]};
        else
            prdata = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_id_reg[0] <= 8'd16;
            cfg_id_reg[1] <= 8'd32;
            cfg_id_reg[2] <= 8'd48;
            cfg_id_reg[3] <= 8'd49;
            cfg_id_reg[4] <= 8'd64;
            cfg_id_reg[5] <= 8'd65;
        end
        else if (psel && penable && pwrite && reg_idx >= REG_ACCEL && reg_idx <= REG_QUAT)
        begin
            cfg_id_reg[reg_idx] <= pwdata[7:0];
        end
    end

    // Hold input while a frame waits in the queue or is being walked
    assign in_stall = busy || !q_empty;
    assign accept   = in_valid && !in_stall;

    imu_fd_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .frame_end(frame_end),
        .push     (push),
        .job      (push_job),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    imu_fd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head    (head),
        .empty   (q_empty),
        .full    (q_full)
    );

    imu_fd_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_id      (cfg_id_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .q_empty     (q_empty),
        .q_head      (head),
        .pop         (pop),
        .busy        (busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .record_kind (record_kind),
        .value_0     (v0),
        .value_1     (v1),
        .value_2     (v2),
        .value_3     (v3),
        .frame_status(frame_status),
        .last_item   (last_item)
    );

    assign value_0 = signed'(v0);
    assign value_1 = signed'(v1);
    assign value_2 = signed'(v2);
    assign value_3 = signed'(v3);

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("frame job pushed into a full queue");

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_item == (record_kind == KIND_STATUS)))
        else $error("last_item disagrees with record kind");

    a_no_write_while_walk: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !busy)
        else $error("payload written while the walk reads it");

    a_pop_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> busy)
        else $error("queue popped without starting the back part");
`endif

endmodule

[src/imu_fd_front.sv]
// Front part: absorbs frame bytes, checks header, length and sums, stores the payload.
module imu_fd_front
    import imu_fd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 256,
    localparam int AW = $clog2(PAYLOAD_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    input  logic          frame_end,
    output logic          push,
    output job_t          job,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [7:0]    wr_data
);

    logic [8:0] byte_count_reg, byte_count_next;
    logic [7:0] plen_reg, plen_next;
    logic [7:0] sum_a_reg, sum_a_next;
    logic [7:0] sum_b_reg, sum_b_next;
    logic [7:0] chk_hi_reg, chk_hi_next;
    logic [7:0] chk_lo_reg, chk_lo_next;
    logic       hdr_ok_reg, hdr_ok_next;
    logic [9:0] p10;
    logic [9:0] plen10;
    logic [9:0] idx;
    logic       in_payload;
    status_t    status;

    always_comb
    begin
        p10             = {1'b0, byte_count_reg};
        plen10          = {2'b00, plen_reg};
        idx             = p10 - 10'd5;
        byte_count_next = byte_count_reg;
        plen_next       = plen_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        chk_hi_next     = chk_hi_reg;
        chk_lo_next     = chk_lo_reg;
        hdr_ok_next     = hdr_ok_reg;
        in_payload      = 1'b0;
        if (p10 == 10'd0)
        begin
            hdr_ok_next = hdr_ok_reg & (rx_byte == HDR_FIRST);
        end
        else if (p10 == 10'd1)
        begin
            hdr_ok_next = hdr_ok_reg & (rx_byte == HDR_SECOND);
        end
        else if (p10 <= 10'd4)
        begin
            if (p10 == 10'd4)
            begin
                plen_next = rx_byte;
            end
            sum_a_next = sum_a_reg + rx_byte;
            sum_b_next = sum_b_reg + sum_a_next;
        end
        else if (p10 < 10'd5 + plen10)
        begin
            in_payload = 1'b1;
            sum_a_next = sum_a_reg + rx_byte;
            sum_b_next = sum_b_reg + sum_a_next;
        end
        else if (p10 == 10'd5 + plen10)
        begin
            chk_hi_next = rx_byte;
        end
        else if (p10 == 10'd6 + plen10)
        begin
            chk_lo_next = rx_byte;
        end
        if (byte_count_reg != COUNT_MAX)
        begin
            byte_count_next = byte_count_reg + 9'd1;
        end

        // Checks in order of precedence
        if (byte_count_next < 9'(MIN_FRAME))
            status = ST_LENGTH;
        else if (!hdr_ok_next)
            status = ST_HEADER;
        else if ({2'b00, plen_next} + 10'(MIN_FRAME) > {1'b0, byte_count_next} ||
                 {2'b00, plen_next} > 10'(PAYLOAD_DEPTH))
            status = ST_LENGTH;
        else if (chk_hi_next != sum_a_next || chk_lo_next != sum_b_next)
            status = ST_CHECKSUM;
        else
            status = ST_OK;
    end

    assign push       = accept & frame_end;
    assign job.status = status;
    assign job.plen   = plen_next;
    assign wr_en      = accept & in_payload & (idx < 10'(PAYLOAD_DEPTH));
    assign wr_addr    = idx[AW-1:0];
    assign wr_data    = rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            plen_reg       <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            chk_hi_reg     <= '0;
            chk_lo_reg     <= '0;
            hdr_ok_reg     <= 1'b1;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                byte_count_reg <= '0;
                plen_reg       <= '0;
                sum_a_reg      <= '0;
                sum_b_reg      <= '0;
                chk_hi_reg     <= '0;
                chk_lo_reg     <= '0;
                hdr_ok_reg     <= 1'b1;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                plen_reg       <= plen_next;
                sum_a_reg      <= sum_a_next;
                sum_b_reg      <= sum_b_next;
                chk_hi_reg     <= chk_hi_next;
                chk_lo_reg     <= chk_lo_next;
                hdr_ok_reg     <= hdr_ok_next;
            end
        end
    end

endmodule

[src/imu_fd_queue.sv]
// Two-entry queue of finished frame jobs between front and back.
module imu_fd_queue
    import imu_fd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop && !empty)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

[src/imu_fd_back.sv]
// Back part: walks the stored payload as records and emits result words.
module imu_fd_back
    import imu_fd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 256,
    localparam int AW = $clog2(PAYLOAD_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    cfg_id [NUM_KINDS],
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          q_empty,
    input  job_t          q_head,
    output logic          pop,
    output logic          busy,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [2:0]    record_kind,
    output logic [31:0]   value_0,
    output logic [31:0]   value_1,
    output logic [31:0]   value_2,
    output logic [31:0]   value_3,
    output logic [2:0]    frame_status,
    output logic          last_item
);

    typedef enum logic [2:0] {
        S_IDLE, S_TOP, S_ID, S_LEN, S_DATA, S_EMIT_REC, S_EMIT_STATUS
    } state_t;

    state_t     state_reg;
    logic [7:0] mem [PAYLOAD_DEPTH];
    logic [7:0] mem_q;
    logic [AW-1:0] rd_addr;
    logic [9:0] pos_reg;
    logic [9:0] plen_reg;
    status_t    status_reg;
    logic [7:0] id_reg;
    logic [2:0] kind_reg;
    logic [4:0] cnt_reg;
    logic [7:0] vals_reg [16];
    logic       out_free;
    logic       emit;
    logic       found;
    logic [2:0] hit;
    logic       rec_ok;
    logic [9:0] rd_pos;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        mem_q <= mem[rd_addr];
    end

    always_comb
    begin
        case (state_reg)
            S_ID:    rd_pos = pos_reg + 10'd1;
            S_DATA:  rd_pos = pos_reg + 10'd2 + {5'd0, cnt_reg};
            default: rd_pos = pos_reg;
        endcase
        rd_addr = rd_pos[AW-1:0];
    end

    // First configured id that matches wins
    always_comb
    begin
        found = 1'b0;
        hit   = '0;
        for (int k = NUM_KINDS - 1; k >= 0; k--)
        begin
            if (cfg_id[k] == id_reg)
            begin
                found = 1'b1;
                hit   = 3'(k);
            end
        end
        rec_ok = found && (mem_q == {3'd0, kind_len(hit)}) &&
                 (pos_reg + 10'd2 + {2'd0, mem_q} <= plen_reg);
    end

    assign out_free = !out_valid || !out_stall;
    assign emit     = out_free && (state_reg == S_EMIT_REC || state_reg == S_EMIT_STATUS);
    assign pop      = (state_reg == S_IDLE) && !q_empty;
    assign busy     = (state_reg != S_IDLE);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DATA && cnt_reg != 5'd0)
            vals_reg[4'(cnt_reg - 5'd1)] <= mem_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_valid    <= 1'b0;
            pos_reg      <= '0;
            plen_reg     <= '0;
            status_reg   <= ST_OK;
            id_reg       <= '0;
            kind_reg     <= '0;
            cnt_reg      <= '0;
            record_kind  <= '0;
            value_0      <= '0;
            value_1      <= '0;
            value_2      <= '0;
            value_3      <= '0;
            frame_status <= '0;
            last_item    <= 1'b0;
        end
        else
        begin
            out_valid <= emit || (out_valid && out_stall);
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        plen_reg   <= {2'd0, q_head.plen};
                        status_reg <= q_head.status;
                        pos_reg    <= '0;
                        state_reg  <= (q_head.status == ST_OK) ? S_TOP : S_EMIT_STATUS;
                    end
                end
                S_TOP:
                begin
                    if (pos_reg >= plen_reg)
                        state_reg <= S_EMIT_STATUS;
                    else if (pos_reg + 10'd1 < plen_reg)
                        state_reg <= S_ID;
                    else
                        pos_reg <= pos_reg + 10'd1;
                end
                S_ID:
                begin
                    id_reg    <= mem_q;
                    state_reg <= S_LEN;
                end
                S_LEN:
                begin
                    if (rec_ok)
                    begin
                        kind_reg  <= hit;
                        cnt_reg   <= '0;
                        state_reg <= S_DATA;
                    end
                    else
                    begin
                        pos_reg   <= pos_reg + 10'd1;
                        state_reg <= S_TOP;
                    end
                end
                S_DATA:
                begin
                    if (cnt_reg == kind_len(kind_reg))
                        state_reg <= S_EMIT_REC;
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                S_EMIT_REC:
                begin
                    if (out_free)
                    begin
                        record_kind  <= kind_reg;
                        value_0      <= {vals_reg[3], vals_reg[2], vals_reg[1], vals_reg[0]};
                        value_1      <= {vals_reg[7], vals_reg[6], vals_reg[5], vals_reg[4]};
                        value_2      <= {vals_reg[11], vals_reg[10], vals_reg[9], vals_reg[8]};
                        value_3      <= (kind_reg == KIND_QUAT) ?
                                        {vals_reg[15], vals_reg[14], vals_reg[13], vals_reg[12]}
                                        : 32'd0;
                        frame_status <= ST_OK;
                        last_item    <= 1'b0;
                        pos_reg      <= pos_reg + 10'd2 + {5'd0, kind_len(kind_reg)};
                        state_reg    <= S_TOP;
                    end
                end
                S_EMIT_STATUS:
                begin
                    if (out_free)
                    begin
                        record_kind  <= KIND_STATUS;
                        value_0      <= '0;
                        value_1      <= '0;
                        value_2      <= '0;
                        value_3      <= '0;
                        frame_status <= status_reg;
                        last_item    <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[verif/imu_frame_decoder_core_test.sv]
// Self-checking testbench of the sensor frame decoder core.
`timescale 1ns / 100ps

module imu_frame_decoder_core_test;
    import imu_fd_pkg::*;

    // Frame shapes that the stimulus can build
    localparam int FR_GOOD    = 0;
    localparam int FR_BAD_HDR = 1;
    localparam int FR_BAD_SUM = 2;
    localparam int FR_SHORT   = 3;
    localparam int FR_TRAIL   = 4;

    localparam int LONG_HOLD  = 1500;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } rx_word_t;

    typedef struct {
        kind_t       kind;
        logic [31:0] val [4];
        status_t     status;
        logic        last;
    } record_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               frame_end;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         record_kind;
    logic signed [31:0] value_0;
    logic signed [31:0] value_1;
    logic signed [31:0] value_2;
    logic signed [31:0] value_3;
    logic [2:0]         frame_status;
    logic               last_item;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    imu_frame_decoder_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_kind  (record_kind),
        .value_0      (value_0),
        .value_1      (value_1),
        .value_2      (value_2),
        .value_3      (value_3),
        .frame_status (frame_status),
        .last_item    (last_item),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Words waiting to be offered, and decoded records waiting to come out
    rx_word_t   tx_words [$];
    record_t    pending_records [$];
    logic [7:0] payload_q [$];
    int         words_queued;
    int         errors;
    logic       hold_req;

    // Predictor copy of the block's registers and frame state
    logic [7:0] rec_id [NUM_KINDS];
    logic [7:0] pay_mem [256];
    logic [8:0] rx_count;
    logic [7:0] pay_len;
    logic [7:0] fl_a;
    logic [7:0] fl_b;
    logic [7:0] chk_hi;
    logic [7:0] chk_lo;
    logic       hdr_ok;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous ceiling on the whole run
    initial
    begin
        #5_000_000;
        $display("imu_frame_decoder_core_test: FAIL");
        $finish;
    end

    function automatic logic [4:0] rec_bytes(input int k);
        return (k == KIND_QUAT) ? 5'd16 : 5'd12;
    endfunction

    function automatic logic [31:0] le32(input int idx);
        return {pay_mem[idx + 3], pay_mem[idx + 2], pay_mem[idx + 1], pay_mem[idx]};
    endfunction

    task automatic clear_frame();
        rx_count = '0;
        pay_len  = '0;
        fl_a     = '0;
        fl_b     = '0;
        chk_hi   = '0;
        chk_lo   = '0;
        hdr_ok   = 1'b1;
    endtask

    // Walk the stored payload and queue one record per matching id and length
    task automatic decode_records();
        int      pos;
        int      hit;
        int      plen;
        record_t r;
        pos  = 0;
        plen = pay_len;
        while (pos < plen)
        begin
            hit = -1;
            if (pos + 1 < plen)
            begin
                for (int k = 0; k < NUM_KINDS; k++)
                begin
                    if (rec_id[k] == pay_mem[pos])
                    begin
                        if (pay_mem[pos + 1] == rec_bytes(k) && pos + 2 + rec_bytes(k) <= plen)
                            hit = k;
                        break;
                    end
                end
            end
            if (hit >= 0)
            begin
                r.kind   = kind_t'(hit);
                r.status = ST_OK;
                r.last   = 1'b0;
                for (int i = 0; i < 4; i++)
                    r.val[i] = (i < rec_bytes(hit) / 4) ? le32(pos + 2 + 4 * i) : '0;
                pending_records.push_back(r);
                pos += 2 + rec_bytes(hit);
            end
            else
                pos++;
        end
    endtask

    // Absorb one accepted word; at frame end, work out the results it causes
    task automatic absorb_word(input logic [7:0] b, input logic e);
        int      p;
        int      plen;
        record_t r;
        p    = rx_count;
        plen = pay_len;
        if (p == 0)
            hdr_ok = hdr_ok && (b == HDR_FIRST);
        else if (p == 1)
            hdr_ok = hdr_ok && (b == HDR_SECOND);
        else if (p <= 4)
        begin
            if (p == 4)
                pay_len = b;
            fl_a = fl_a + b;
            fl_b = fl_b + fl_a;
        end
        else if (p < 5 + plen)
        begin
            pay_mem[p - 5] = b;
            fl_a = fl_a + b;
            fl_b = fl_b + fl_a;
        end
        else if (p == 5 + plen)
            chk_hi = b;
        else if (p == 6 + plen)
            chk_lo = b;
        if (rx_count != COUNT_MAX)
            rx_count = rx_count + 1;
        if (e)
        begin
            p    = rx_count;
            plen = pay_len;
            if (p < MIN_FRAME)
                r.status = ST_LENGTH;
            else if (!hdr_ok)
                r.status = ST_HEADER;
            else if (plen + MIN_FRAME > p)
                r.status = ST_LENGTH;
            else if (chk_hi != fl_a || chk_lo != fl_b)
                r.status = ST_CHECKSUM;
            else
                r.status = ST_OK;
            if (r.status == ST_OK)
                decode_records();
            r.kind = KIND_STATUS;
            r.last = 1'b1;
            for (int i = 0; i < 4; i++)
                r.val[i] = '0;
            pending_records.push_back(r);
            clear_frame();
        end
    endtask

    function automatic logic [7:0] data_byte();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h80;
            3: return 8'h7f;
            default: return 8'($urandom);
        endcase
    endfunction

    // Append one record of the given kind, optionally with a wrong length
    task automatic add_record(input int k, input bit bad_len);
        int n;
        n = rec_bytes(k);
        payload_q.push_back(rec_id[k]);
        payload_q.push_back(bad_len ? 8'(n + $urandom_range(1, 4)) : 8'(n));
        for (int i = 0; i < n; i++)
            payload_q.push_back(data_byte());
    endtask

    // Fill payload_q with a random mix of records, noise and, now and then, a cut-off record
    task automatic random_payload(input int target);
        int pick;
        payload_q.delete();
        while (payload_q.size() < target)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                add_record($urandom_range(0, NUM_KINDS - 1), 1'b0);
            else if (pick == 6)
                add_record($urandom_range(0, NUM_KINDS - 1), 1'b1);
            else
                payload_q.push_back(8'($urandom));
        end
        // Cut a record short at the end of the payload now and then
        if ($urandom_range(0, 3) == 0)
        begin
            add_record($urandom_range(0, NUM_KINDS - 1), 1'b0);
            payload_q = payload_q[0:payload_q.size() - $urandom_range(1, 10)];
        end
        while (payload_q.size() > 255)
            void'(payload_q.pop_back());
    endtask

    // Frame payload_q and queue its words for the driver
    task automatic send_frame(input int shape, input int extra);
        logic [7:0] w [$];
        logic [7:0] a;
        logic [7:0] b;
        int         cut;
        w = {HDR_FIRST, HDR_SECOND, 8'($urandom), 8'($urandom), 8'(payload_q.size())};
        w = {w, payload_q};
        a = '0;
        b = '0;
        for (int i = 2; i < w.size(); i++)
        begin
            a = a + w[i];
            b = b + a;
        end
        w.push_back(a);
        w.push_back(b);
        case (shape)
            FR_BAD_HDR: w[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            FR_BAD_SUM: w[w.size() - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            FR_SHORT:
            begin
                cut = $urandom_range(1, w.size() - 1);
                w = w[0:cut - 1];
            end
            FR_TRAIL:
                for (int i = 0; i < extra; i++)
                    w.push_back(8'($urandom));
            default: ;
        endcase
        foreach (w[i])
            tx_words.push_back('{data: w[i], last: (i == w.size() - 1)});
        words_queued += w.size();
    endtask

    // Wait until the block has drained, then give the back end time to settle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (tx_words.size() != 0 || in_valid || pending_records.size() != 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(4 * idx);
        pwdata  <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx < NUM_KINDS)
            rec_id[idx] = value;
    endtask

    // Driver: offer words in bursts of random length, hold while stalled
    int burst_left;
    int gap_left;
    rx_word_t next_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            rx_byte    <= '0;
            frame_end  <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (tx_words.size() != 0)
            begin
                next_word = tx_words.pop_front();
                in_valid  <= 1'b1;
                rx_byte   <= next_word.data;
                frame_end <= next_word.last;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: switch stall pattern now and then; one long hold-off on request
    int stall_mode;
    int mode_left;
    int hold_left;
    bit hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode = 0;
            mode_left  = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= (hold_left != 0);
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 1) == 1);
                2: out_stall <= (mode_left % 4 != 0);
                default: out_stall <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Input side: every accepted word goes through the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            absorb_word(rx_byte, frame_end);
    end

    // Output side: compare each accepted word with the oldest expectation
    record_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_records.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected output word: kind %0d status %0d",
                             record_kind, frame_status);
            end
            else
            begin
                want = pending_records.pop_front();
                if (record_kind !== want.kind || value_0 !== want.val[0]
                    || value_1 !== want.val[1] || value_2 !== want.val[2]
                    || value_3 !== want.val[3] || frame_status !== want.status
                    || last_item !== want.last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected kind %0d vals %h %h %h %h st %0d last %0d,",
                                  " got kind %0d vals %h %h %h %h st %0d last %0d"},
                                 want.kind, want.val[0], want.val[1], want.val[2],
                                 want.val[3], want.status, want.last, record_kind,
                                 value_0, value_1, value_2, value_3, frame_status,
                                 last_item);
                end
            end
        end
    end

    int shape;

    initial
    begin
        errors       = 0;
        words_queued = 0;
        hold_req     = 1'b0;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rec_id       = '{8'd16, 8'd32, 8'd48, 8'd49, 8'd64, 8'd65};
        clear_frame();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at reset ids: empty payload, each kind, noise, broken frames
        payload_q.delete();
        send_frame(FR_GOOD, 0);
        for (int k = 0; k < NUM_KINDS; k++)
            add_record(k, 1'b0);
        send_frame(FR_GOOD, 0);
        payload_q = {8'h10, 8'h0c};
        for (int i = 0; i < 12; i++)
            payload_q.push_back(8'hff);
        payload_q = {payload_q, 8'h41, 8'h10, 8'h80, 8'h00, 8'h20, 8'h0b, 8'h41, 8'h10};
        send_frame(FR_GOOD, 0);
        random_payload(10);
        send_frame(FR_BAD_HDR, 0);
        random_payload(10);
        send_frame(FR_BAD_SUM, 0);
        random_payload(10);
        send_frame(FR_SHORT, 0);
        tx_words.push_back('{data: HDR_FIRST, last: 1'b1});
        payload_q.delete();
        send_frame(FR_TRAIL, 3);
        wait_idle();

        // Extreme ids, a duplicate pair, and a write past the last register
        write_reg(0, 8'h00);
        write_reg(1, 8'h00);
        write_reg(2, 8'hff);
        write_reg(3, 8'h7f);
        write_reg(4, 8'h80);
        write_reg(5, 8'hfe);
        write_reg(6, 8'h33);
        for (int k = 0; k < NUM_KINDS; k++)
            add_record(k, 1'b0);
        send_frame(FR_GOOD, 0);
        wait_idle();

        // Random phases, each under fresh random ids
        for (int ph = 0; ph < 2; ph++)
        begin
            for (int k = 0; k < NUM_KINDS; k++)
                write_reg(k, ($urandom_range(0, 3) == 0) ? rec_id[0] : 8'($urandom));
            if (ph == 0)
                hold_req <= 1'b1;
            words_queued = 0;
            while (words_queued < 30)
            begin
                random_payload($urandom_range(0, 30));
                shape = $urandom_range(0, 9);
                send_frame(shape < 6 ? FR_GOOD : (shape == 6 ? FR_BAD_HDR :
                           (shape == 7 ? FR_BAD_SUM : (shape == 8 ? FR_SHORT : FR_TRAIL))),
                           $urandom_range(1, 5));
            end
            wait_idle();
        end

        // Restore reset ids for a last short random run
        write_reg(0, 8'd16);
        write_reg(1, 8'd32);
        write_reg(2, 8'd48);
        write_reg(3, 8'd49);
        write_reg(4, 8'd64);
        write_reg(5, 8'd65);
        for (int f = 0; f < 2; f++)
        begin
            random_payload($urandom_range(0, 15));
            send_frame(FR_GOOD, 0);
        end
        wait_idle();

        if (errors == 0 && pending_records.size() == 0)
            $display("imu_frame_decoder_core_test: PASS");
        else
            $display("imu_frame_decoder_core_test: FAIL");
        $finish;
    end

endmodule
